// ----- design/lae_pkg.sv -----
package lae_pkg;

	localparam int LEVEL_FRAC_BITS = 24;
	localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	// register reset values
	localparam logic [LEVEL_W-1:0] ATTACK_RESET  = LEVEL_W'(16777);
	localparam logic [LEVEL_W-1:0] DECAY_RESET   = LEVEL_W'(3495);
	localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = LEVEL_W'(11744051);
	localparam logic [LEVEL_W-1:0] RELEASE_RESET = LEVEL_W'(1165);

	// decay step for the reset rate and sustain
	localparam logic [LEVEL_W-1:0] DECAY_DEC_RESET = LEVEL_W'(
		(64'(DECAY_RESET) * (64'(LEVEL_ONE) - 64'(SUSTAIN_RESET))) >> LEVEL_FRAC_BITS);

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_DECAY   = 2'd1;
	localparam logic [1:0] REG_SUSTAIN = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;

	typedef enum logic [2:0] {
		ST_OFF     = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} env_stage_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] note;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [2:0]         stage;
		logic               active;
	} out_item_t;

	// saturated settings and the precomputed decay step
	typedef struct packed {
		logic [LEVEL_W-1:0] attack;
		logic [LEVEL_W-1:0] sustain;
		logic [LEVEL_W-1:0] release_step;
		logic [LEVEL_W-1:0] decay_dec;
	} cfg_t;

	function automatic logic [LEVEL_W-1:0] sat_one(input logic [LEVEL_W-1:0] v);
		return (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

endpackage

// ----- design/lae_cfg.sv -----
module lae_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [lae_pkg::LEVEL_W-1:0]   cfg_data,
	output lae_pkg::cfg_t                 cfg
);

	logic [lae_pkg::LEVEL_W-1:0]   attack_q;
	logic [lae_pkg::LEVEL_W-1:0]   decay_q;
	logic [lae_pkg::LEVEL_W-1:0]   sustain_q;
	logic [lae_pkg::LEVEL_W-1:0]   release_q;
	logic [lae_pkg::LEVEL_W-1:0]   dec_q;
	logic [lae_pkg::LEVEL_W-1:0]   nxt_decay;
	logic [lae_pkg::LEVEL_W-1:0]   nxt_sustain;
	logic [2*lae_pkg::LEVEL_W-1:0] dec_prod;

	// store values already clipped to 1.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= lae_pkg::ATTACK_RESET;
			decay_q   <= lae_pkg::DECAY_RESET;
			sustain_q <= lae_pkg::SUSTAIN_RESET;
			release_q <= lae_pkg::RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lae_pkg::REG_ATTACK:  attack_q  <= lae_pkg::sat_one(cfg_data);
				lae_pkg::REG_DECAY:   decay_q   <= lae_pkg::sat_one(cfg_data);
				lae_pkg::REG_SUSTAIN: sustain_q <= lae_pkg::sat_one(cfg_data);
				lae_pkg::REG_RELEASE: release_q <= lae_pkg::sat_one(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// rate and sustain as they stand after this edge
	assign nxt_decay   = (cfg_we && cfg_index == lae_pkg::REG_DECAY) ?
		lae_pkg::sat_one(cfg_data) : decay_q;
	assign nxt_sustain = (cfg_we && cfg_index == lae_pkg::REG_SUSTAIN) ?
		lae_pkg::sat_one(cfg_data) : sustain_q;

	// decay step = rate * (1 - sustain), truncated; never above 1.0
	assign dec_prod = nxt_decay * (lae_pkg::LEVEL_ONE - nxt_sustain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= lae_pkg::DECAY_DEC_RESET;
		end else begin
			dec_q <= dec_prod[lae_pkg::LEVEL_FRAC_BITS +: lae_pkg::LEVEL_W];
		end
	end

	assign cfg.attack       = attack_q;
	assign cfg.sustain      = sustain_q;
	assign cfg.release_step = release_q;
	assign cfg.decay_dec    = dec_q;

endmodule

// ----- design/linear_adsr_envelope.sv -----
// Single-voice linear ADSR envelope, levels in unsigned Q1.24 (1.0 = 2^24).
// Input channel (in_valid / in_stall / in_data): one event per transfer,
// op = tick, note on or note off, with a note number.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// event, giving level, stage and active after that event is applied.
// Configuration: cfg_we with cfg_index and cfg_data writes attack step,
// decay rate, sustain level or release step; values above 1.0 act as 1.0.
// Write these only while no event is in flight.
// Path: an event goes through the input register, then the result register,
// and transfers out from the result register. Throughput: one event per
// cycle when out_stall is low; the state update is one add and compare per
// event, and the decay step product is registered with the settings it is
// made from.
// Stall: when out_stall holds the result register, the input register
// fills and in_stall rises; no event is lost or repeated.
// Reset: stage off, level 0, held note 0, registers at their defaults,
// both pipeline registers empty.
module linear_adsr_envelope (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lae_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lae_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [lae_pkg::LEVEL_W-1:0] cfg_data
);

	lae_pkg::cfg_t cfg;

	logic                 valid_s1;
	lae_pkg::in_item_t    item_s1;
	logic                 valid_s2;
	lae_pkg::out_item_t   result_s2;

	lae_pkg::env_stage_t         stage_q;
	logic [lae_pkg::LEVEL_W-1:0] level_q;
	logic [6:0]                  note_q;

	lae_pkg::env_stage_t         nxt_stage;
	logic [lae_pkg::LEVEL_W-1:0] nxt_level;
	logic [6:0]                  nxt_note;

	logic                        adv_s2;
	logic                        move;
	logic                        accept;
	logic [lae_pkg::LEVEL_W:0]   att_sum;
	logic [lae_pkg::LEVEL_W:0]   dec_lim;

	lae_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: the result register advances when empty or taken.
	assign adv_s2    = !valid_s2 || !out_stall;
	assign move      = valid_s1 && adv_s2;
	assign in_stall  = valid_s1 && !adv_s2;
	assign accept    = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Step sums, one bit wider so the compare never wraps.
	assign att_sum = {1'b0, level_q} + {1'b0, cfg.attack};
	assign dec_lim = {1'b0, cfg.sustain} + {1'b0, cfg.decay_dec};

	// Next envelope state for the event in the input register.
	always_comb begin
		nxt_stage = stage_q;
		nxt_level = level_q;
		nxt_note  = note_q;
		case (item_s1.op)
			lae_pkg::OP_TICK: begin
				case (stage_q)
					lae_pkg::ST_ATTACK: begin
						if (att_sum >= {1'b0, lae_pkg::LEVEL_ONE}) begin
							nxt_level = lae_pkg::LEVEL_ONE;
							nxt_stage = lae_pkg::ST_DECAY;
						end else begin
							nxt_level = att_sum[lae_pkg::LEVEL_W-1:0];
						end
					end
					lae_pkg::ST_DECAY: begin
						// land on the sustain level, even if already below it
						if ({1'b0, level_q} <= dec_lim) begin
							nxt_level = cfg.sustain;
							nxt_stage = lae_pkg::ST_SUSTAIN;
						end else begin
							nxt_level = level_q - cfg.decay_dec;
						end
					end
					lae_pkg::ST_SUSTAIN: begin
						nxt_level = cfg.sustain;
					end
					lae_pkg::ST_RELEASE: begin
						if (level_q <= cfg.release_step) begin
							nxt_level = '0;
							nxt_stage = lae_pkg::ST_OFF;
						end else begin
							nxt_level = level_q - cfg.release_step;
						end
					end
					default: begin
						nxt_level = '0;
						nxt_stage = lae_pkg::ST_OFF;
					end
				endcase
			end
			lae_pkg::OP_NOTE_ON: begin
				nxt_note  = item_s1.note;
				nxt_stage = lae_pkg::ST_ATTACK;
				nxt_level = '0;
			end
			lae_pkg::OP_NOTE_OFF: begin
				// only the held note, and only from attack, decay or sustain
				if (stage_q != lae_pkg::ST_OFF && stage_q != lae_pkg::ST_RELEASE &&
						note_q == item_s1.note) begin
					nxt_stage = lae_pkg::ST_RELEASE;
				end
			end
			default: begin
			end
		endcase
	end

	// Commit state and present the result on the same transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= lae_pkg::ST_OFF;
			level_q <= '0;
			note_q  <= '0;
		end else if (move) begin
			stage_q <= nxt_stage;
			level_q <= nxt_level;
			note_q  <= nxt_note;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			result_s2.level  <= (nxt_stage == lae_pkg::ST_OFF) ? '0 : nxt_level;
			result_s2.stage  <= nxt_stage;
			result_s2.active <= (nxt_stage != lae_pkg::ST_OFF);
		end
	end

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= lae_pkg::LEVEL_ONE)
		else $error("envelope level above full scale");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == lae_pkg::ST_OFF |-> level_q == '0)
		else $error("nonzero level while off");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!move |=> $stable(stage_q) && $stable(level_q) && $stable(note_q))
		else $error("envelope state changed without a transfer");

	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.active == (result_s2.stage != lae_pkg::ST_OFF))
		else $error("active flag disagrees with stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipeline");

endmodule
